// ===== design/sts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;

	typedef enum logic [3:0] {
		ST_IN,
		ST_POS,
		ST_SUM,
		ST_SHIFT,
		ST_SQR,
		ST_SQRT,
		ST_DIV,
		ST_MPOS,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [15:0] tu;
		logic signed [15:0] tv;
	} corner_t;

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [15:0] tu;
		logic signed [15:0] tv;
	} vtx_t;

	localparam int NUM_OUT = 12;

	// slot numbers: 0..2 corners, 3 = m01, 4 = m02, 5 = m12
	localparam logic [2:0] SLOT_C0  = 3'd0;
	localparam logic [2:0] SLOT_C1  = 3'd1;
	localparam logic [2:0] SLOT_C2  = 3'd2;
	localparam logic [2:0] SLOT_M01 = 3'd3;
	localparam logic [2:0] SLOT_M02 = 3'd4;
	localparam logic [2:0] SLOT_M12 = 3'd5;

	function automatic logic [2:0] out_slot(input logic [3:0] k);
		logic [2:0] s;
		unique case (k)
			4'd0: s = SLOT_M01;
			4'd1: s = SLOT_C1;
			4'd2: s = SLOT_M12;
			4'd3: s = SLOT_C0;
			4'd4: s = SLOT_M01;
			4'd5: s = SLOT_M02;
			4'd6: s = SLOT_M02;
			4'd7: s = SLOT_M01;
			4'd8: s = SLOT_M12;
			4'd9: s = SLOT_M02;
			4'd10: s = SLOT_M12;
			4'd11: s = SLOT_C2;
			default: s = SLOT_C0;
		endcase
		return s;
	endfunction

	// round Q10.22 product to Q10.14: add 2^7, floor shift by 8
	function automatic logic signed [23:0] round_pos(input logic signed [32:0] prod);
		logic signed [32:0] r;
		r = prod + 33'sd128;
		return r[31:8];
	endfunction

endpackage
`default_nettype wire

// ===== design/sts_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring integer square root, one result bit per cycle.
module sts_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [49:0] radicand,
	output logic             done,
	output logic [24:0]      root
);
	logic [49:0] rem_q;
	logic [49:0] rad_q;
	logic [24:0] res_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [51:0] trial;
	logic [51:0] rem_sh;

	assign rem_sh = {rem_q, rad_q[49:48]};
	assign trial = {rem_sh[51:0]} - {25'd0, res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			res_q <= '0;
			rad_q <= radicand;
		end else if (busy_q) begin
			rad_q <= {rad_q[47:0], 2'b00};
			if (!trial[51]) begin
				rem_q <= trial[49:0];
				res_q <= {res_q[23:0], 1'b1};
			end else begin
				rem_q <= rem_sh[49:0];
				res_q <= {res_q[23:0], 1'b0};
			end
		end
	end

	assign root = res_q;
endmodule
`default_nettype wire

// ===== design/sts_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle: q = floor(num / den).
module sts_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [39:0] num,
	input  wire logic [25:0] den,
	output logic             done,
	output logic [15:0]      quo
);
	logic [39:0] num_q;
	logic [25:0] den_q;
	logic [26:0] rem_q;
	logic [15:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [26:0] rem_sh;
	logic [26:0] diff;

	assign rem_sh = {rem_q[25:0], num_q[39]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd39;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[38:0], 1'b0};
			if (!diff[26]) begin
				rem_q <= diff;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule
`default_nettype wire

// ===== design/sphere_triangle_subdivider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sphere triangle subdivider.
// s_axis carries corners in triangle order; tdata = {tex_v, tex_u, normal_z,
// normal_y, normal_x} (normal_x lowest). The first two beats of a triangle are
// stored. The third starts the sequencer: corner positions via one shared
// 16x17 multiplier (one per cycle), then per midpoint a sum, a normalizing
// shift (at most 23 steps), three squares, a bit-serial square root, three
// bit-serial divisions and three position products; a zero-length midpoint
// goes from the shift straight to the position products. Then come 12 output
// beats. From the third corner until the last output beat is taken,
// s_axis_tready stays low; the serial sqrt/divide units dominate that time.
// m_axis emits the 12 vertices of four triangles with tlast on the twelfth;
// tdata holds positions, normals, texcoords, index (see port comment). The
// output holds its beat while m_axis_tready is low, and the
// sequencer waits. sphere_radius is written through cfg_we/cfg_data.
// Reset (arst_n low) clears the corner count, index counter, sequencer and
// sets the radius to 1.0 (256). Held corners are undefined until written.
module sphere_triangle_subdivider #(
	parameter int INDEX_BITS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// normal_x, normal_y, normal_z, tex_u, tex_v
	input  wire logic [79:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// pos_x, pos_y, pos_z, out_normal_x, out_normal_y, out_normal_z,
	// out_tex_u, out_tex_v, vertex_index
	output logic [175:0]      m_axis_tdata,
	output logic              m_axis_tlast
);
	sts_pkg::state_t state_q, state_d;

	logic [15:0] radius_q;
	logic [1:0]  corner_cnt_q;
	logic [INDEX_BITS-1:0] idx_q;
	sts_pkg::corner_t corner_q [3];
	sts_pkg::vtx_t    vtx_q [6];

	logic [3:0] step_q;   // component / slot counter
	logic [1:0] mid_q;    // which midpoint
	logic [1:0] comp_q;
	logic [4:0] shift_q;
	logic signed [24:0] sum_q [3];
	logic [49:0] l2_q;
	logic [24:0] len_q;
	logic [3:0]  emit_q;

	logic s_fire, m_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == sts_pkg::ST_IN);

	sts_pkg::corner_t in_r;
	assign in_r.nx = s_axis_tdata[15:0];
	assign in_r.ny = s_axis_tdata[31:16];
	assign in_r.nz = s_axis_tdata[47:32];
	assign in_r.tu = s_axis_tdata[63:48];
	assign in_r.tv = s_axis_tdata[79:64];

	// corner position pass: step 0..8 walks corner 0..2, component x, y, z
	logic [1:0] pos_c, pos_k;
	always_comb begin
		unique case (step_q)
			4'd0: begin pos_c = 2'd0; pos_k = 2'd0; end
			4'd1: begin pos_c = 2'd0; pos_k = 2'd1; end
			4'd2: begin pos_c = 2'd0; pos_k = 2'd2; end
			4'd3: begin pos_c = 2'd1; pos_k = 2'd0; end
			4'd4: begin pos_c = 2'd1; pos_k = 2'd1; end
			4'd5: begin pos_c = 2'd1; pos_k = 2'd2; end
			4'd6: begin pos_c = 2'd2; pos_k = 2'd0; end
			4'd7: begin pos_c = 2'd2; pos_k = 2'd1; end
			default: begin pos_c = 2'd2; pos_k = 2'd2; end
		endcase
	end

	// midpoint corners
	logic [2:0] ma, mb;
	always_comb begin
		unique case (mid_q)
			2'd0: begin ma = sts_pkg::SLOT_C0; mb = sts_pkg::SLOT_C1; end
			2'd1: begin ma = sts_pkg::SLOT_C0; mb = sts_pkg::SLOT_C2; end
			default: begin ma = sts_pkg::SLOT_C1; mb = sts_pkg::SLOT_C2; end
		endcase
	end

	// shared multiplier: signed 16 x unsigned 16
	logic signed [15:0] mul_a;
	logic signed [32:0] mul_p;
	assign mul_p = mul_a * $signed({1'b0, radius_q});

	logic [24:0] mag [3];
	logic [24:0] mmax;
	always_comb begin
		for (int i = 0; i < 3; i++)
			mag[i] = sum_q[i][24] ? 25'(-sum_q[i]) : 25'(sum_q[i]);
		mmax = mag[0];
		if (mag[1] > mmax) mmax = mag[1];
		if (mag[2] > mmax) mmax = mag[2];
	end

	// selected magnitude (shifted)
	logic [24:0] mag_c;
	assign mag_c = mag[comp_q];
	logic [23:0] mag_sh;
	assign mag_sh = 24'(mag_c << shift_q);

	logic sq_start, sq_done, dv_start, dv_done;
	logic [24:0] sq_root;
	logic [15:0] dv_quo;
	logic [47:0] sq_term;
	assign sq_term = mag_sh * mag_sh;

	// running sum of squares including the current term; the root starts
	// on the last square so it takes the full sum
	logic [49:0] l2_sum;
	assign l2_sum = l2_q + 50'(sq_term);

	sts_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(l2_sum),
		.done(sq_done), .root(sq_root)
	);
	sts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num({1'b0, mag_sh, 15'd0} + 40'(len_q)),
		.den({len_q, 1'b0}), .done(dv_done), .quo(dv_quo)
	);

	logic [2:0] mslot;
	assign mslot = 3'(3'(mid_q) + sts_pkg::SLOT_M01);

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		dv_start = 1'b0;
		mul_a    = '0;
		unique case (state_q)
			sts_pkg::ST_IN:    if (s_fire && corner_cnt_q == 2'd2) state_d = sts_pkg::ST_POS;
			sts_pkg::ST_POS: begin
				unique case (pos_k)
					2'd0:    mul_a = corner_q[pos_c].nx;
					2'd1:    mul_a = corner_q[pos_c].ny;
					default: mul_a = corner_q[pos_c].nz;
				endcase
				if (step_q == 4'd8) state_d = sts_pkg::ST_SUM;
			end
			sts_pkg::ST_SUM:   state_d = sts_pkg::ST_SHIFT;
			sts_pkg::ST_SHIFT: begin
				if (mmax == '0) state_d = sts_pkg::ST_MPOS;
				else if (25'(mmax << shift_q) >= 25'h800000) state_d = sts_pkg::ST_SQR;
			end
			sts_pkg::ST_SQR: if (comp_q == 2'd2) begin
				state_d = sts_pkg::ST_SQRT; sq_start = 1'b1;
			end
			sts_pkg::ST_SQRT: if (sq_done) begin
				state_d = sts_pkg::ST_DIV;
			end
			sts_pkg::ST_DIV: begin
				if (step_q == 4'd0) dv_start = 1'b1;
				if (dv_done && comp_q == 2'd2) state_d = sts_pkg::ST_MPOS;
			end
			sts_pkg::ST_MPOS: begin
				unique case (comp_q)
					2'd0:    mul_a = vtx_q[mslot].nx;
					2'd1:    mul_a = vtx_q[mslot].ny;
					default: mul_a = vtx_q[mslot].nz;
				endcase
				if (comp_q == 2'd2)
					state_d = (mid_q == 2'd2) ? sts_pkg::ST_EMIT : sts_pkg::ST_SUM;
			end
			sts_pkg::ST_EMIT:
				if (m_fire && emit_q == 4'(sts_pkg::NUM_OUT - 1)) state_d = sts_pkg::ST_IN;
			default: state_d = sts_pkg::ST_IN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sts_pkg::ST_IN;
			radius_q     <= 16'd256;
			corner_cnt_q <= '0;
			idx_q        <= '0;
			step_q <= '0; mid_q <= '0; comp_q <= '0; shift_q <= '0; emit_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) radius_q <= cfg_data;
			if (s_fire) corner_cnt_q <= (corner_cnt_q == 2'd2) ? 2'd0 : corner_cnt_q + 2'd1;
			unique case (state_q)
				sts_pkg::ST_IN: begin step_q <= '0; mid_q <= '0; end
				sts_pkg::ST_POS: step_q <= step_q + 4'd1;
				sts_pkg::ST_SUM: begin shift_q <= '0; comp_q <= '0; end
				sts_pkg::ST_SHIFT:
					if (mmax != '0 && 25'(mmax << shift_q) < 25'h800000)
						shift_q <= shift_q + 5'd1;
				sts_pkg::ST_SQR: comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
				sts_pkg::ST_SQRT: step_q <= '0;
				sts_pkg::ST_DIV: begin
					if (dv_done) begin
						step_q <= '0;
						comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
					end else begin
						step_q <= 4'd1;
					end
				end
				sts_pkg::ST_MPOS: begin
					comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
					if (comp_q == 2'd2) begin
						mid_q <= mid_q + 2'd1;
						if (mid_q == 2'd2) m_axis_tvalid <= 1'b1;
					end
				end
				sts_pkg::ST_EMIT: if (m_fire) begin
					idx_q <= idx_q + 1'b1;
					if (emit_q == 4'(sts_pkg::NUM_OUT - 1)) begin
						emit_q <= '0;
						m_axis_tvalid <= 1'b0;
					end else begin
						emit_q <= emit_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_fire) corner_q[corner_cnt_q] <= in_r;
		unique case (state_q)
			sts_pkg::ST_POS: begin
				unique case (pos_k)
					2'd0:    vtx_q[pos_c].px <= sts_pkg::round_pos(mul_p);
					2'd1:    vtx_q[pos_c].py <= sts_pkg::round_pos(mul_p);
					default: vtx_q[pos_c].pz <= sts_pkg::round_pos(mul_p);
				endcase
				if (step_q < 4'd3) begin
					vtx_q[step_q[1:0]].nx <= corner_q[step_q[1:0]].nx;
					vtx_q[step_q[1:0]].ny <= corner_q[step_q[1:0]].ny;
					vtx_q[step_q[1:0]].nz <= corner_q[step_q[1:0]].nz;
					vtx_q[step_q[1:0]].tu <= corner_q[step_q[1:0]].tu;
					vtx_q[step_q[1:0]].tv <= corner_q[step_q[1:0]].tv;
				end
			end
			sts_pkg::ST_SUM: begin
				sum_q[0] <= 25'(vtx_q[ma].px) + 25'(vtx_q[mb].px);
				sum_q[1] <= 25'(vtx_q[ma].py) + 25'(vtx_q[mb].py);
				sum_q[2] <= 25'(vtx_q[ma].pz) + 25'(vtx_q[mb].pz);
				vtx_q[mslot].tu <= 16'((17'(vtx_q[ma].tu) + 17'(vtx_q[mb].tu)) >>> 1);
				vtx_q[mslot].tv <= 16'((17'(vtx_q[ma].tv) + 17'(vtx_q[mb].tv)) >>> 1);
				vtx_q[mslot].nx <= '0;
				vtx_q[mslot].ny <= '0;
				vtx_q[mslot].nz <= '0;
				l2_q <= '0;
			end
			sts_pkg::ST_SQR: l2_q <= l2_sum;
			sts_pkg::ST_SQRT: if (sq_done) len_q <= sq_root;
			sts_pkg::ST_DIV: if (dv_done) begin
				unique case (comp_q)
					2'd0: vtx_q[mslot].nx <= sum_q[0][24] ? -dv_quo : dv_quo;
					2'd1: vtx_q[mslot].ny <= sum_q[1][24] ? -dv_quo : dv_quo;
					default: vtx_q[mslot].nz <= sum_q[2][24] ? -dv_quo : dv_quo;
				endcase
			end
			sts_pkg::ST_MPOS: begin
				unique case (comp_q)
					2'd0: vtx_q[mslot].px <= sts_pkg::round_pos(mul_p);
					2'd1: vtx_q[mslot].py <= sts_pkg::round_pos(mul_p);
					default: vtx_q[mslot].pz <= sts_pkg::round_pos(mul_p);
				endcase
			end
			default: ;
		endcase
	end

	sts_pkg::vtx_t ov;
	assign ov = vtx_q[sts_pkg::out_slot(emit_q)];
	assign m_axis_tdata = {24'(idx_q), ov.tv, ov.tu, ov.nz, ov.ny, ov.nx,
		ov.pz, ov.py, ov.px};
	assign m_axis_tlast = (emit_q == 4'(sts_pkg::NUM_OUT - 1));

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input taken while emitting");
	a_emit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> state_q == sts_pkg::ST_EMIT) else $error("valid outside emit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(emit_q)) else $error("slot moved");
endmodule
`default_nettype wire
